@@ hdl/binary_to_padded_decimal_text_defines.svh @@
// assertion macros for the binary to padded decimal text block
// used by bpdt_checker; expects clk and rst in scope
`ifndef BINARY_TO_PADDED_DECIMAL_TEXT_DEFINES_SVH
`define BINARY_TO_PADDED_DECIMAL_TEXT_DEFINES_SVH

// same-cycle implication
`define BPDT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bpdt assertion failed");

// next-cycle implication
`define BPDT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bpdt assertion failed");

`endif

@@ hdl/bpdt_pkg.sv @@
// shared types and constants for the binary to padded decimal text block
// no dependencies
package bpdt_pkg;

  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;
  localparam logic [7:0]  ASCII_ZERO  = 8'h30;
  localparam logic [7:0]  ASCII_SPACE = 8'h20;
  localparam int          IN_BYTES    = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_PREP,
    ST_PAD,
    ST_DIG
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic prep;
    logic emit_pad;
    logic emit_dig;
  } cmd_t;

  typedef struct packed {
    logic more;
    logic pads_zero;
    logic last_dig;
    logic out_free;
  } status_t;

endpackage

@@ hdl/bpdt_ctrl.sv @@
// controller state machine for the decimal text converter
// depends on bpdt_pkg
module bpdt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  bpdt_pkg::status_t st,
  output bpdt_pkg::cmd_t   cmd
);
  import bpdt_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_MUL;
      end
      ST_MUL: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        state_next = st.more ? ST_MUL : ST_PREP;
      end
      ST_PREP: begin
        state_next = ST_PAD;
      end
      ST_PAD: begin
        if (st.pads_zero) state_next = ST_DIG;
      end
      ST_DIG: begin
        if (st.out_free && st.last_dig) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
      end
      ST_PAD: begin
        cmd.emit_pad = !st.pads_zero && st.out_free;
      end
      ST_DIG: begin
        cmd.emit_dig = st.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ hdl/bpdt_dpath.sv @@
// datapath: reciprocal divide by ten, digit store, pad count, output register
// depends on bpdt_pkg
module bpdt_dpath #(
  parameter int MAX_DIGITS = 10,
  parameter int MAX_WIDTH  = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [31:0]       number,
  input  logic [5:0]        field_width,
  input  logic              pad_with_space,
  input  bpdt_pkg::cmd_t    cmd,
  output bpdt_pkg::status_t st,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,
  output logic              m_tlast
);
  import bpdt_pkg::*;

  localparam int DW = $clog2(MAX_DIGITS + 1);
  localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [31:0]   value;
  logic [63:0]   prod;
  logic [3:0]    digits [MAX_DIGITS];
  logic [DW-1:0] ndig;
  logic [WW-1:0] wid;
  logic [WW-1:0] pads;
  logic          pad_space;

  logic [28:0]   quot;
  logic [31:0]   quot32;
  logic [31:0]   rem32;
  logic [DW-1:0] rd_idx;
  logic [3:0]    rd_digit;
  logic [6:0]    fw7;
  logic [6:0]    maxw7;
  logic [6:0]    wid_sat;

  assign quot     = prod[63:RECIP_SHIFT];
  assign quot32   = {3'b000, quot};
  assign rem32    = value - ((quot32 << 3) + (quot32 << 1));
  assign rd_idx   = ndig - DW'(1);
  assign rd_digit = digits[rd_idx[IW-1:0]];
  assign fw7      = {1'b0, field_width};
  assign maxw7    = 7'(MAX_WIDTH);
  assign wid_sat  = (fw7 > maxw7) ? maxw7 : fw7;

  assign st.more      = (quot != '0) && (ndig < DW'(MAX_DIGITS - 1));
  assign st.pads_zero = (pads == '0);
  assign st.last_dig  = (ndig == DW'(1));
  assign st.out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value     <= number;
      wid       <= WW'(wid_sat);
      pad_space <= pad_with_space;
      ndig      <= '0;
    end
    if (cmd.mul) begin
      prod <= 64'(value) * 64'(RECIP_TEN);
    end
    if (cmd.div) begin
      digits[ndig[IW-1:0]] <= rem32[3:0];
      value                <= quot32;
      ndig                 <= ndig + DW'(1);
    end
    if (cmd.prep) begin
      if (8'(wid) > 8'(ndig)) begin
        pads <= WW'(8'(wid) - 8'(ndig));
      end else begin
        pads <= '0;
      end
    end
    if (cmd.emit_pad) begin
      pads <= pads - WW'(1);
    end
    if (cmd.emit_dig) begin
      ndig <= rd_idx;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_pad || cmd.emit_dig) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_pad) begin
      m_tdata <= pad_space ? ASCII_SPACE : ASCII_ZERO;
      m_tlast <= 1'b0;
    end else if (cmd.emit_dig) begin
      m_tdata <= ASCII_ZERO | {4'b0000, rd_digit};
      m_tlast <= st.last_dig;
    end
  end

endmodule

@@ hdl/binary_to_padded_decimal_text.sv @@
// top level of the binary to padded decimal text converter
// depends on bpdt_pkg, bpdt_ctrl and bpdt_dpath
//
// Takes one 32-bit unsigned number per input beat and sends it as ASCII decimal
// text, one character per output beat, pad characters first and tlast on the
// final digit. One number is worked on at a time: the divide by ten runs on a
// single shared reciprocal multiplier, one digit per multiply and divide step,
// then the pad count is set up and each character leaves when the output side
// is ready. The output register lets the next number be taken while the last
// character still waits.
module binary_to_padded_decimal_text #(
  parameter int MAX_DIGITS = 10,
  parameter int MAX_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // number [31:0], field_width [37:32], zero fill
  input  logic        s_tuser,  // pad_with_space
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // character [7:0]
  output logic        m_tlast
);
  import bpdt_pkg::*;

  cmd_t    cmd;
  status_t st;

  bpdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  bpdt_dpath #(
    .MAX_DIGITS (MAX_DIGITS),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .number         (s_tdata[31:0]),
    .field_width    (s_tdata[37:32]),
    .pad_with_space (s_tuser),
    .cmd            (cmd),
    .st             (st),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast)
  );

endmodule

@@ hdl/bpdt_checker.sv @@
// port-level checks for the binary to padded decimal text converter
// depends on binary_to_padded_decimal_text_defines.svh; bound to the top level
`include "binary_to_padded_decimal_text_defines.svh"

module bpdt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tlast
);

  // stalled beat holds
  `BPDT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
                    m_tvalid && $stable(m_tdata) && $stable(m_tlast))
  // only digits or space leave the block
  `BPDT_ASSERT_IMPL(a_char_set, m_tvalid,
                    ((m_tdata >= 8'h30) && (m_tdata <= 8'h39)) || (m_tdata == 8'h20))
  // the final character is always a digit
  `BPDT_ASSERT_IMPL(a_last_digit, m_tvalid && m_tlast, m_tdata != 8'h20)
  // one number at a time
  `BPDT_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)

endmodule

bind binary_to_padded_decimal_text bpdt_checker u_bpdt_checker (.*);
